>>> design/owr_pkg.sv
// Shared types and constants of the 1-Wire reset and presence detector.
`default_nettype none
package owr_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int CFG_W          = 10;

    localparam logic [CFG_W-1:0] IDLE_WAIT_RST  = CFG_W'(200);
    localparam logic [CFG_W-1:0] LOW_PULSE_RST  = CFG_W'(480);
    localparam logic [CFG_W-1:0] PRES_WIN_RST   = CFG_W'(480);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_HIGH = 3'd1,
        PH_LOW       = 3'd2,
        PH_WAIT_FALL = 3'd3,
        PH_WAIT_RISE = 3'd4,
        PH_PAD       = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_PRESENCE = 2'd0,
        ST_STUCK    = 2'd1,
        ST_ABSENT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_IDLE_WAIT = 2'd1,
        REG_LOW_PULSE = 2'd2,
        REG_PRES_WIN  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        FN_TICK  = 1'b0,
        FN_START = 1'b1
    } t_func;

    typedef struct packed {
        logic             ext_pullup;
        logic [CFG_W-1:0] idle_wait;
        logic [CFG_W-1:0] low_pulse;
        logic [CFG_W-1:0] pres_win;
    } t_cfg;

    typedef struct packed {
        logic    drive_low;
        logic    busy_res;
        logic    done_res;
        t_status status;
    } t_result;

endpackage
`default_nettype wire

>>> design/owr_core.sv
// Reset and presence sequencer: phase and countdown state, one beat per cycle while input is accepted.
`default_nettype none
module owr_core
    import owr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic    i_func,
    input  wire logic    i_bus_level,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CW-1:0] TMAX = CW'((1 << TIMER_BITS) - 1);

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_count, n_count;
    logic [TIMER_BITS-1:0] dec;
    logic                  padded;

    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CFG_W-1:0] v);
        logic [CW-1:0] w;
        begin
            w = CW'(v);
            if (w == '0) begin
                w = CW'(1);
            end else if (w > TMAX) begin
                w = TMAX;
            end
            return w[TIMER_BITS-1:0];
        end
    endfunction

    assign dec = r_count - TIMER_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (t_func'(i_func) == FN_START) begin
            if (r_phase == PH_IDLE) begin
                if (i_cfg.ext_pullup) begin
                    n_phase = PH_WAIT_HIGH;
                    n_count = sat_load(i_cfg.idle_wait);
                end else begin
                    n_phase = PH_LOW;
                    n_count = sat_load(i_cfg.low_pulse);
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_WAIT_HIGH: begin
                    if (i_bus_level) begin
                        n_phase = PH_LOW;
                        n_count = sat_load(i_cfg.low_pulse);
                    end else begin
                        n_count = dec;
                        if (dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_LOW: begin
                    if (dec == '0) begin
                        n_phase = PH_WAIT_FALL;
                        n_count = sat_load(i_cfg.pres_win);
                    end else begin
                        n_count = dec;
                    end
                end
                PH_WAIT_FALL, PH_WAIT_RISE, PH_PAD: begin
                    if (r_phase == PH_WAIT_FALL && !i_bus_level) begin
                        n_phase = PH_WAIT_RISE;
                    end else if (r_phase == PH_WAIT_RISE && i_bus_level) begin
                        n_phase = PH_PAD;
                    end
                    n_count = dec;
                    if (dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        padded = (r_phase == PH_PAD) || (r_phase == PH_WAIT_RISE && i_bus_level);
        o_result.drive_low = (n_phase == PH_LOW);
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = (t_func'(i_func) == FN_TICK) && (n_phase == PH_IDLE) &&
                             (r_phase == PH_WAIT_HIGH || r_phase == PH_WAIT_FALL ||
                              r_phase == PH_WAIT_RISE || r_phase == PH_PAD);
        o_result.status    = ST_PRESENCE;
        if (o_result.done_res) begin
            if (r_phase == PH_WAIT_HIGH) begin
                o_result.status = ST_STUCK;
            end else if (!padded) begin
                o_result.status = ST_ABSENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> design/owr_outq.sv
// Two-entry result buffer between the sequencer and the output channel.
`default_nettype none
module owr_outq
    import owr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_data
);

    t_result    r_head, r_tail;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && i_pop_ready;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_head;
    assign n_cnt   = r_cnt + 2'(i_push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_head <= i_data;
        end else if (pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end
        if (i_push && r_cnt == 2'd1 && !pop) begin
            r_tail <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> design/one_wire_reset_presence.sv
// Top level of the 1-Wire reset and presence detector with its register port.
//
// Each accepted beat is one microsecond tick carrying the sampled bus level, or a
// start request, and yields exactly one result beat. A beat is taken every cycle:
// the phase/countdown update is a single pass of logic and the result is written
// into a two-entry output buffer at acceptance, so input stalls only when both
// buffer entries hold results not yet taken. The countdown is TIMER_BITS wide;
// timing registers load saturated to 1 .. 2^TIMER_BITS-1.
`default_nettype none
module one_wire_reset_presence
    import owr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic        i_bus_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_drive_low,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic      [1:0]  o_status
);

    t_cfg     r_cfg;
    t_result  core_res, q_res;
    t_reg_idx reg_idx;
    logic     accept;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_pullup <= 1'b1;
            r_cfg.idle_wait  <= IDLE_WAIT_RST;
            r_cfg.low_pulse  <= LOW_PULSE_RST;
            r_cfg.pres_win   <= PRES_WIN_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MODE:      r_cfg.ext_pullup <= pwdata[0];
                REG_IDLE_WAIT: r_cfg.idle_wait  <= pwdata[CFG_W-1:0];
                REG_LOW_PULSE: r_cfg.low_pulse  <= pwdata[CFG_W-1:0];
                REG_PRES_WIN:  r_cfg.pres_win   <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:      prdata = 32'(r_cfg.ext_pullup);
            REG_IDLE_WAIT: prdata = 32'(r_cfg.idle_wait);
            REG_LOW_PULSE: prdata = 32'(r_cfg.low_pulse);
            REG_PRES_WIN:  prdata = 32'(r_cfg.pres_win);
            default:       prdata = '0;
        endcase
    end

    owr_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_bus_level (i_bus_level),
        .i_cfg       (r_cfg),
        .o_result    (core_res)
    );

    owr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_res),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (q_res)
    );

    assign o_drive_low = q_res.drive_low;
    assign o_busy_res  = q_res.busy_res;
    assign o_done_res  = q_res.done_res;
    assign o_status    = q_res.status;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && !o_drive_low)
        else $error("done beat reports busy or drive");

    a_drive_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res)
        else $error("bus driven low outside a sequence");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_status == ST_PRESENCE)
        else $error("status set without done");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule
`default_nettype wire
